// ----- design/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg
// Types and constants shared by the spectrum peak finder modules.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int IDX_W   = 10;
    localparam int PART_W  = 22;
    localparam int BIN_W   = 9;
    localparam int MAG_W   = 22;
    localparam int MARGIN_W = 22;
    localparam int RATE_W  = 16;
    localparam int RATEQ_W = 25;
    localparam int SQ_W    = 2 * PART_W;
    localparam int REM_W   = MAG_W + 2;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int CNT_W   = $clog2(ROOT_STEPS);
    localparam int IN_W    = 56;
    localparam int OUT_W   = 56;
    localparam int ADDR_W  = 4;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_START_BIN = 2'd0;
    localparam reg_idx_t REG_MARGIN    = 2'd1;
    localparam reg_idx_t REG_RATE      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RE,
        ST_MUL_IM,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_UPDATE,
        ST_EMIT
    } spf_state_t;

    typedef struct packed {
        logic load_in;
        logic mul_re;
        logic mul_im;
        logic root_load;
        logic root_step;
        logic update;
        logic emit;
    } spf_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } spf_status_t;

    typedef struct packed {
        logic [BIN_W-1:0]    start_bin;
        logic [MARGIN_W-1:0] margin;
        logic [RATE_W-1:0]   rate_per_bin_q8;
    } spf_cfg_t;

endpackage

// ----- design/spf_cfg.sv -----
// ----------------------------------------------------------------------------
// spf_cfg
// Configuration register file behind the APB port.
// ----------------------------------------------------------------------------
module spf_cfg
    import spf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output spf_cfg_t          cfg
);

    logic [BIN_W-1:0]    start_bin_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic                wr_en;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_bin_reg <= BIN_W'(10);
            margin_reg    <= '0;
            rate_reg      <= RATE_W'(1500);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_START_BIN: start_bin_reg <= pwdata[BIN_W-1:0];
                REG_MARGIN:    margin_reg    <= pwdata[MARGIN_W-1:0];
                REG_RATE:      rate_reg      <= pwdata[RATE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_BIN: prdata = {{(32-BIN_W){1'b0}}, start_bin_reg};
            REG_MARGIN:    prdata = {{(32-MARGIN_W){1'b0}}, margin_reg};
            REG_RATE:      prdata = {{(32-RATE_W){1'b0}}, rate_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.start_bin       = start_bin_reg;
    assign cfg.margin          = margin_reg;
    assign cfg.rate_per_bin_q8 = rate_reg;

endmodule

// ----- design/spf_ctrl.sv -----
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer: input request, squares, square-root loop, update, result.
// ----------------------------------------------------------------------------
module spf_ctrl
    import spf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  spf_status_t status,
    output spf_cmd_t    cmd
);

    spf_state_t       state_reg;
    spf_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL_RE;
                end
            end
            ST_MUL_RE:
            begin
                cmd.mul_re = 1'b1;
                state_next = ST_MUL_IM;
            end
            ST_MUL_IM:
            begin
                cmd.mul_im = 1'b1;
                state_next = ST_ROOT_LOAD;
            end
            ST_ROOT_LOAD:
            begin
                cmd.root_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/spf_dp.sv -----
// ----------------------------------------------------------------------------
// spf_dp
// Datapath: magnitude by shared multiplier and bit-pair square root,
// running best bin, result register.
// ----------------------------------------------------------------------------
module spf_dp
    import spf_pkg::*;
#(
    parameter int BINS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  spf_cmd_t         cmd,
    output spf_status_t      status,
    input  spf_cfg_t         cfg,
    input  logic [IN_W-1:0]  in_data,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    localparam int unsigned HALF_BINS = BINS / 2;

    logic [IDX_W-1:0]   idx_reg;
    logic [PART_W-1:0]  re_reg;
    logic [PART_W-1:0]  im_reg;
    logic               last_reg;
    logic [SQ_W-1:0]    sq_re_reg;
    logic [SQ_W-1:0]    sq_im_reg;
    logic [SQ_W-1:0]    rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [MAG_W-1:0]   root_reg;
    logic [MAG_W-1:0]   best_mag_reg;
    logic [BIN_W-1:0]   best_bin_reg;
    logic [BIN_W-1:0]   out_bin_reg;
    logic [MAG_W-1:0]   out_mag_reg;
    logic [RATEQ_W-1:0] out_rate_reg;
    logic               out_valid_reg;

    logic [PART_W-1:0]  re_raw;
    logic [PART_W-1:0]  im_raw;
    logic [PART_W-1:0]  re_abs;
    logic [PART_W-1:0]  im_abs;
    logic [PART_W-1:0]  mul_op;
    logic [SQ_W-1:0]    sq;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic               fits;
    logic [REM_W+1:0]   rem_sub;
    logic               in_window;
    logic [MAG_W:0]     thresh;
    logic               beats;

    assign re_raw = in_data[IDX_W +: PART_W];
    assign im_raw = in_data[IDX_W+PART_W +: PART_W];
    assign re_abs = re_raw[PART_W-1] ? PART_W'(~re_raw + 1'b1) : re_raw;
    assign im_abs = im_raw[PART_W-1] ? PART_W'(~im_raw + 1'b1) : im_raw;

    assign mul_op = cmd.mul_im ? im_reg : re_reg;
    assign sq     = SQ_W'(mul_op) * SQ_W'(mul_op);

    assign rem_sh  = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial   = (REM_W+2)'({root_reg, 2'b01});
    assign fits    = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    assign in_window = (IDX_W'(cfg.start_bin) <= idx_reg) && (32'(idx_reg) < HALF_BINS);
    assign thresh    = (MAG_W+1)'(best_mag_reg) + (MAG_W+1)'(cfg.margin);
    assign beats     = (MAG_W+1)'(root_reg) > thresh;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            idx_reg  <= in_data[IDX_W-1:0];
            re_reg   <= re_abs;
            im_reg   <= im_abs;
            last_reg <= in_last;
        end
        if (cmd.mul_re)
            sq_re_reg <= sq;
        if (cmd.mul_im)
            sq_im_reg <= sq;
        if (cmd.root_load)
        begin
            rad_reg  <= sq_re_reg + sq_im_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= fits ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[MAG_W-2:0], fits};
        end
        if (cmd.emit)
        begin
            out_bin_reg  <= best_bin_reg;
            out_mag_reg  <= best_mag_reg;
            out_rate_reg <= RATEQ_W'(best_bin_reg) * RATEQ_W'(cfg.rate_per_bin_q8);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_mag_reg  <= '0;
            best_bin_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                best_mag_reg <= '0;
                best_bin_reg <= '0;
            end
            else if (cmd.update && in_window && beats)
            begin
                best_mag_reg <= root_reg;
                best_bin_reg <= idx_reg[BIN_W-1:0];
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {out_rate_reg, out_mag_reg, out_bin_reg};

endmodule

// ----- design/spectrum_peak_finder.sv -----
// ----------------------------------------------------------------------------
// spectrum_peak_finder
// Peak bin search over a stream of FFT bins by integer magnitude.
// ----------------------------------------------------------------------------
// Pacing: a new bin is accepted only once the previous one has left the
//   22-step square-root loop in the datapath and the update state.
// Result: registered in the emit state after the last bin, once the output is free.
// Reset: start_bin 10, margin 0, rate_per_bin_q8 1500; best bin and
//   magnitude cleared; no result pending.
module spectrum_peak_finder
    import spf_pkg::*;
#(
    parameter int BINS = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,  // bin_index, real_part, imag_part, zero pad
    input  logic              s_axis_tlast,  // last_bin
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,  // peak_bin, peak_magnitude, rate_q8
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    spf_cfg_t    cfg;
    spf_cmd_t    cmd;
    spf_status_t status;

    spf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spf_dp #(
        .BINS (BINS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- tb/sv/spectrum_peak_finder_tb.sv -----
// ----------------------------------------------------------------------------
// spectrum_peak_finder_tb
// Self-checking bench for the FFT peak bin finder.
// Bins are streamed in with random gaps. Each peak report is checked field by
// field against a bench-side model of the magnitude search or a typed table
// result. A directed table runs first, then random spectra under several
// register settings, with one long output stall to back the block up.
// ----------------------------------------------------------------------------
module spectrum_peak_finder_tb;

    import spf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS         = 1024;
    localparam int SETTLE       = 40;
    localparam int STALL_LIMIT  = 6000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;

    typedef struct packed {
        logic              last;
        logic [PART_W-1:0] im;
        logic [PART_W-1:0] re;
        logic [IDX_W-1:0]  idx;
    } fft_bin_t;

    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic [MAG_W-1:0]   mag;
        logic [RATEQ_W-1:0] rate;
    } peak_t;

    typedef struct {
        fft_bin_t b;
        bit       typed;
        peak_t    res;
    } table_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;   // bin_index, real_part, imag_part, zero pad
    logic              s_axis_tlast = 1'b0; // last_bin
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // peak_bin, peak_magnitude, rate_q8
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    spectrum_peak_finder #(.BINS(BINS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    spf_cfg_t          cfg = '{start_bin: 9'd10, margin: '0, rate_per_bin_q8: 16'd1500};
    logic [MAG_W-1:0]  best_mag = '0;
    logic [BIN_W-1:0]  best_bin = '0;
    peak_t             expected_peaks[$];
    table_row_t        rows[$];
    int                mismatches = 0;
    int                idle_cycles = 0;
    bit                quiet = 1'b0;
    bit                hold_request = 1'b0;
    bit                hold_done = 1'b0;

    function automatic logic [MAG_W-1:0] magnitude(input logic [PART_W-1:0] re,
                                                   input logic [PART_W-1:0] im);
        logic [PART_W-1:0] ar;
        logic [PART_W-1:0] ai;
        longint unsigned   sq;
        longint unsigned   trial;
        logic [MAG_W-1:0]  root;
        ar = re[PART_W-1] ? -re : re;
        ai = im[PART_W-1] ? -im : im;
        sq = 64'(ar) * 64'(ar) + 64'(ai) * 64'(ai);
        root = '0;
        for (int k = MAG_W - 1; k >= 0; k--)
        begin
            trial = 64'(root) | (64'd1 << k);
            if (trial * trial <= sq)
                root = trial[MAG_W-1:0];
        end
        return root;
    endfunction

    // updates the running peak; returns 1 when the bin closes a spectrum
    function automatic bit track_peak(input fft_bin_t b, output peak_t r);
        logic [MAG_W-1:0] mag;
        logic [MAG_W:0]   bar;
        mag = magnitude(b.re, b.im);
        bar = {1'b0, best_mag} + cfg.margin;
        if (b.idx >= cfg.start_bin && b.idx < BINS / 2 && {1'b0, mag} > bar)
        begin
            best_mag = mag;
            best_bin = b.idx[BIN_W-1:0];
        end
        r.bin  = best_bin;
        r.mag  = best_mag;
        r.rate = RATEQ_W'(best_bin) * RATEQ_W'(cfg.rate_per_bin_q8);
        if (b.last)
        begin
            best_mag = '0;
            best_bin = '0;
        end
        return b.last;
    endfunction

    function automatic logic [PART_W-1:0] rand_part(input bit full);
        logic [31:0] v;
        v = full ? $urandom() : $urandom_range(0, 100) - 50;
        return v[PART_W-1:0];
    endfunction

    task automatic add_row(input int idx, input int re, input int im, input bit last,
                           input bit typed, input int pb, input int pm, input int pr);
        table_row_t t;
        t.b = '{last: last, im: im[PART_W-1:0], re: re[PART_W-1:0], idx: idx[IDX_W-1:0]};
        t.typed = typed;
        t.res = '{bin: pb[BIN_W-1:0], mag: pm[MAG_W-1:0], rate: pr[RATEQ_W-1:0]};
        rows.push_back(t);
    endtask

    task automatic offer_bin(input fft_bin_t b, input bit typed, input peak_t typed_res);
        peak_t pred;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tdata  <= {2'b00, b.im, b.re, b.idx};
        s_axis_tlast  <= b.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        if (track_peak(b, pred))
            expected_peaks.push_back(typed ? typed_res : pred);
    endtask

    task automatic wait_for_peaks();
        s_axis_tvalid <= 1'b0;
        while (expected_peaks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (r)
            REG_START_BIN: cfg.start_bin       = v[BIN_W-1:0];
            REG_MARGIN:    cfg.margin          = v[MARGIN_W-1:0];
            REG_RATE:      cfg.rate_per_bin_q8 = v[RATE_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic configure(input int start, input int margin, input int rate);
        wait_for_peaks();
        write_reg(REG_START_BIN, start);
        write_reg(REG_MARGIN, margin);
        write_reg(REG_RATE, rate);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // output checker
    always @(posedge clk)
    begin
        peak_t got;
        peak_t exp_peak;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{bin: m_axis_tdata[8:0], mag: m_axis_tdata[30:9],
                    rate: m_axis_tdata[55:31]};
            if (expected_peaks.size() == 0)
            begin
                $error("unexpected peak report: bin %0d mag %0d rate %0d",
                       got.bin, got.mag, got.rate);
                mismatches++;
            end
            else
            begin
                exp_peak = expected_peaks.pop_front();
                if (got.bin !== exp_peak.bin)
                begin
                    $error("peak_bin expected %0d got %0d", exp_peak.bin, got.bin);
                    mismatches++;
                end
                if (got.mag !== exp_peak.mag)
                begin
                    $error("peak_magnitude expected %0d got %0d", exp_peak.mag, got.mag);
                    mismatches++;
                end
                if (got.rate !== exp_peak.rate)
                begin
                    $error("rate_q8 expected %0d got %0d", exp_peak.rate, got.rate);
                    mismatches++;
                end
            end
        end
    end

    // receiver: random back-pressure plus one long hold
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        fft_bin_t b;
        peak_t    none;
        int       sent;
        int       len;
        int       base;
        int       margin_pick;
        bit       full;
        bit       ended;

        none = '0;
        // reset settings: start 10, margin 0, rate 1500
        add_row(0, 0, 0, 1, 1, 0, 0, 0);
        add_row(10, -2097152, -2097152, 1, 0, 0, 0, 0);
        add_row(511, 2097151, 0, 1, 1, 511, 2097151, 766500);
        add_row(512, 1000, 0, 1, 1, 0, 0, 0);
        add_row(1023, -1, -1, 1, 1, 0, 0, 0);
        add_row(10, 3, 4, 0, 0, 0, 0, 0);
        add_row(11, 5, 0, 0, 0, 0, 0, 0);
        add_row(9, 2097151, 2097151, 0, 0, 0, 0, 0);
        add_row(12, -6, 8, 0, 0, 0, 0, 0);
        add_row(600, -2097152, 2097151, 0, 0, 0, 0, 0);
        add_row(12, 0, -10, 0, 0, 0, 0, 0);
        add_row(5, 0, 0, 0, 0, 0, 0, 0);
        add_row(300, 2097151, -2097152, 0, 0, 0, 0, 0);
        add_row(20, 7, 7, 1, 0, 0, 0, 0);
        add_row(0, 2097151, -2097152, 0, 0, 0, 0, 0);
        add_row(100, -2097152, 2097151, 1, 0, 0, 0, 0);
        add_row(10, 0, 1, 1, 1, 10, 1, 15000);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            offer_bin(rows[i].b, rows[i].typed, rows[i].res);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            margin_pick = $urandom_range(0, 2);
            case (phase)
                0: configure(0, 0, 65535);
                1: configure(511, 3000000, 0);
                2: configure(511, 0, 65535);
                default:
                    configure($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                        : $urandom_range(0, 40),
                              margin_pick == 0 ? 0 :
                              margin_pick == 1 ? $urandom_range(0, 20)
                                               : $urandom_range(0, 3000000),
                              $urandom_range(0, 65535));
            endcase
            if (phase == 4)
                hold_request = 1'b1;
            if (phase == PHASES - 1)
                quiet = 1'b1;
            sent = 0;
            ended = 1'b1;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    // well-formed spectrum near the search window
                    len = $urandom_range(1, 40);
                    full = 1'($urandom_range(0, 1));
                    base = int'(cfg.start_bin) - $urandom_range(0, 3);
                    if (base < 0)
                        base = 0;
                    if ($urandom_range(0, 7) == 0)
                        base = $urandom_range(0, 1023);
                    for (int k = 0; k < len; k++)
                    begin
                        b.idx  = IDX_W'((base + k) % BINS);
                        if ($urandom_range(0, 7) == 0)
                            b.idx = IDX_W'($urandom_range(0, 1023));
                        b.re   = rand_part(full);
                        b.im   = rand_part(full);
                        b.last = (k == len - 1);
                        offer_bin(b, 1'b0, none);
                        ended = b.last;
                        sent++;
                    end
                end
                else
                begin
                    b.idx  = IDX_W'($urandom_range(0, 1023));
                    b.re   = rand_part(1'($urandom_range(0, 1)));
                    b.im   = rand_part(1'($urandom_range(0, 1)));
                    b.last = ($urandom_range(0, 3) == 0);
                    offer_bin(b, 1'b0, none);
                    ended = b.last;
                    sent++;
                end
            end
            if (!ended)
            begin
                b.idx  = IDX_W'($urandom_range(0, 1023));
                b.re   = rand_part(1'b1);
                b.im   = rand_part(1'b1);
                b.last = 1'b1;
                offer_bin(b, 1'b0, none);
            end
        end

        wait_for_peaks();
        if (expected_peaks.size() != 0)
        begin
            $error("%0d peak reports never arrived", expected_peaks.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
